// File: rtl/ordered_action_set_table_macros.svh
// ----------------------------------------------------------------------------
// ordered_action_set_table assertion macros
// Concurrent check wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ACTION_SET_TABLE_MACROS_SVH
`define ORDERED_ACTION_SET_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define OAST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oast: check failed");

// consequent must hold in the cycle after the antecedent
`define OAST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oast: check failed");

`else

`define OAST_ASSERT_SAME(label, clk, rst, ante, cons)
`define OAST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/oast_pkg.sv
// ----------------------------------------------------------------------------
// oast_pkg
// Shared codes, types and the action rank table of the ordered action set.
// ----------------------------------------------------------------------------
package oast_pkg;

   // request modes
   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_CLEAR   = 2'd1;
   localparam logic [1:0] MODE_EXECUTE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // write status codes
   localparam logic [1:0] WSTAT_INSERTED = 2'd0;
   localparam logic [1:0] WSTAT_REPLACED = 2'd1;
   localparam logic [1:0] WSTAT_DROPPED  = 2'd2;

   // stop causes
   localparam logic [1:0] STOP_NONE   = 2'd0;
   localparam logic [1:0] STOP_GROUP  = 2'd1;
   localparam logic [1:0] STOP_OUTPUT = 2'd2;

   // action type codes
   localparam logic [15:0] TYPE_OUTPUT       = 16'd0;
   localparam logic [15:0] TYPE_COPY_TTL_OUT = 16'd11;
   localparam logic [15:0] TYPE_COPY_TTL_IN  = 16'd12;
   localparam logic [15:0] TYPE_SET_MPLS_TTL = 16'd15;
   localparam logic [15:0] TYPE_DEC_MPLS_TTL = 16'd16;
   localparam logic [15:0] TYPE_PUSH_VLAN    = 16'd17;
   localparam logic [15:0] TYPE_POP_VLAN     = 16'd18;
   localparam logic [15:0] TYPE_PUSH_MPLS    = 16'd19;
   localparam logic [15:0] TYPE_POP_MPLS     = 16'd20;
   localparam logic [15:0] TYPE_SET_QUEUE    = 16'd21;
   localparam logic [15:0] TYPE_GROUP        = 16'd22;
   localparam logic [15:0] TYPE_SET_NW_TTL   = 16'd23;
   localparam logic [15:0] TYPE_DEC_NW_TTL   = 16'd24;
   localparam logic [15:0] TYPE_SET_FIELD    = 16'd25;
   localparam logic [15:0] TYPE_PUSH_PBB     = 16'd26;
   localparam logic [15:0] TYPE_POP_PBB      = 16'd27;
   localparam logic [15:0] TYPE_EXPERIMENTER = 16'd65535;

   // rank codes, ascending precedence order (10, 20, ... 79, 80, 90)
   localparam logic [3:0] RANK_10 = 4'd0;
   localparam logic [3:0] RANK_20 = 4'd1;
   localparam logic [3:0] RANK_30 = 4'd2;
   localparam logic [3:0] RANK_40 = 4'd3;
   localparam logic [3:0] RANK_50 = 4'd4;
   localparam logic [3:0] RANK_60 = 4'd5;
   localparam logic [3:0] RANK_70 = 4'd6;
   localparam logic [3:0] RANK_75 = 4'd7;
   localparam logic [3:0] RANK_79 = 4'd8;
   localparam logic [3:0] RANK_80 = 4'd9;
   localparam logic [3:0] RANK_90 = 4'd10;

   // datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_CLEAR,
      DP_SCAN,
      DP_REPLACE,
      DP_SHIFT_PREP,
      DP_SHIFT,
      DP_INSERT,
      DP_EX_READ,
      DP_EX_NEXT,
      DP_EX_END
   } dp_op_type;

   // result selection for the output register
   typedef enum logic [2:0] {
      RSP_INSERTED,
      RSP_REPLACED,
      RSP_DROPPED,
      RSP_EMPTY,
      RSP_EXEC
   } rsp_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic match;
      logic full;
      logic empty;
      logic shift_done;
      logic ex_fin;
   } dp_stat_type;

   // precedence rank of an action type
   function automatic logic [3:0] rank_of(input logic [15:0] ty);
      logic [3:0] rk;
      case (ty)
         TYPE_COPY_TTL_IN:                              rk = RANK_10;
         TYPE_POP_VLAN, TYPE_POP_MPLS, TYPE_POP_PBB:    rk = RANK_20;
         TYPE_PUSH_VLAN, TYPE_PUSH_MPLS, TYPE_PUSH_PBB: rk = RANK_30;
         TYPE_COPY_TTL_OUT:                             rk = RANK_40;
         TYPE_DEC_MPLS_TTL, TYPE_DEC_NW_TTL:            rk = RANK_50;
         TYPE_SET_MPLS_TTL, TYPE_SET_NW_TTL,
         TYPE_SET_FIELD:                                rk = RANK_60;
         TYPE_SET_QUEUE:                                rk = RANK_70;
         TYPE_EXPERIMENTER:                             rk = RANK_75;
         TYPE_GROUP:                                    rk = RANK_80;
         TYPE_OUTPUT:                                   rk = RANK_90;
         default:                                       rk = RANK_79;
      endcase
      return rk;
   endfunction

endpackage

// File: rtl/oast_dp.sv
// ----------------------------------------------------------------------------
// oast_dp
// Datapath: entry memory, scan and shift pointers, result register.
// ----------------------------------------------------------------------------
module oast_dp
   import oast_pkg::*;
#(
   parameter int SET_DEPTH   = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [15:0] req_action_type,
   input  logic [31:0] req_action_ref,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_write_status,
   output logic [15:0] rsp_out_type,
   output logic [31:0] rsp_out_ref,
   output logic [1:0]  rsp_stop_cause,
   output logic        rsp_last
);

   localparam int AW   = $clog2(SET_DEPTH);
   localparam int CW   = $clog2(SET_DEPTH + 1);
   localparam int KEEP = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

   // entry memory
   logic [15:0]     type_mem   [SET_DEPTH];
   logic [KEEP-1:0] handle_mem [SET_DEPTH];
   logic [3:0]      rank_mem   [SET_DEPTH];

   // captured request
   logic [15:0]     cmd_type_ff;
   logic [KEEP-1:0] cmd_handle_ff;
   logic [3:0]      cmd_rank_ff;

   // control registers
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          match_ff, match_in;
   logic [AW-1:0] match_idx_ff, match_idx_in;
   logic          pos_found_ff, pos_found_in;
   logic [CW-1:0] pos_ff, pos_in;

   // registered read data
   logic [15:0]     rd_type_ff;
   logic [KEEP-1:0] rd_handle_ff;
   logic [3:0]      rd_rank_ff;

   // result register
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  wstat_ff, wstat_in;
   logic [15:0] otype_ff, otype_in;
   logic [31:0] oref_ff, oref_in;
   logic [1:0]  stop_ff, stop_in;
   logic        last_ff, last_in;

   // memory port controls
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            wr_all;
   logic            wr_handle;
   logic [AW-1:0]   wr_addr;
   logic [15:0]     wr_type;
   logic [KEEP-1:0] wr_handle_data;
   logic [3:0]      wr_rank;

   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;
   logic          hit_type;
   logic          hit_rank;
   logic [1:0]    rd_stop;

   assign ptr_dec  = ptr_ff - CW'(1);
   assign ptr_inc  = ptr_ff + CW'(1);
   assign hit_type = (rd_type_ff == cmd_type_ff) && (cmd_type_ff != TYPE_SET_FIELD);
   assign hit_rank = cmd_rank_ff < rd_rank_ff;

   // stop cause of the entry under the execute pointer
   always_comb begin
      if (rd_type_ff == TYPE_GROUP) begin
         rd_stop = STOP_GROUP;
      end else if (rd_type_ff == TYPE_OUTPUT) begin
         rd_stop = STOP_OUTPUT;
      end else begin
         rd_stop = STOP_NONE;
      end
   end

   // status back to the controller
   assign stat.scan_done  = (ptr_ff == count_ff) && !rd_vld_ff;
   assign stat.match      = match_ff;
   assign stat.full       = count_ff == CW'(SET_DEPTH);
   assign stat.empty      = count_ff == '0;
   assign stat.shift_done = (ptr_ff == pos_ff) && !rd_vld_ff;
   assign stat.ex_fin     = (rd_stop != STOP_NONE) || (ptr_inc == count_ff);

   // memory access per operation
   always_comb begin
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[AW-1:0];
      wr_all         = 1'b0;
      wr_handle      = 1'b0;
      wr_addr        = pos_ff[AW-1:0];
      wr_type        = cmd_type_ff;
      wr_handle_data = cmd_handle_ff;
      wr_rank        = cmd_rank_ff;
      case (cmd.op)
         DP_SCAN: begin
            rd_en = ptr_ff < count_ff;
         end
         DP_SHIFT: begin
            rd_en   = ptr_ff > pos_ff;
            rd_addr = ptr_dec[AW-1:0];
            if (rd_vld_ff) begin
               wr_all         = 1'b1;
               wr_addr        = rd_idx_ff + AW'(1);
               wr_type        = rd_type_ff;
               wr_handle_data = rd_handle_ff;
               wr_rank        = rd_rank_ff;
            end
         end
         DP_REPLACE: begin
            wr_handle = 1'b1;
            wr_addr   = match_idx_ff;
         end
         DP_INSERT: begin
            wr_all = 1'b1;
         end
         DP_EX_READ: begin
            rd_en = 1'b1;
         end
         DP_EX_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // pointer and flag updates
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      pos_found_in = pos_found_ff;
      pos_in       = pos_ff;
      case (cmd.op)
         DP_LOAD: begin
            ptr_in       = '0;
            rd_vld_in    = 1'b0;
            match_in     = 1'b0;
            pos_found_in = 1'b0;
            pos_in       = count_ff;
         end
         DP_CLEAR, DP_EX_END: begin
            count_in = '0;
         end
         DP_SCAN: begin
            rd_vld_in = rd_en;
            if (rd_en) begin
               ptr_in    = ptr_inc;
               rd_idx_in = ptr_ff[AW-1:0];
            end
            // first same-type entry and first entry of higher rank
            if (rd_vld_ff) begin
               if (hit_type && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = rd_idx_ff;
               end
               if (hit_rank && !pos_found_ff) begin
                  pos_found_in = 1'b1;
                  pos_in       = CW'(rd_idx_ff);
               end
            end
         end
         DP_SHIFT_PREP: begin
            ptr_in    = count_ff;
            rd_vld_in = 1'b0;
         end
         DP_SHIFT: begin
            rd_vld_in = rd_en;
            if (rd_en) begin
               ptr_in    = ptr_dec;
               rd_idx_in = ptr_dec[AW-1:0];
            end
         end
         DP_INSERT: begin
            count_in = count_ff + CW'(1);
         end
         DP_EX_NEXT: begin
            ptr_in = ptr_inc;
         end
         default: begin
         end
      endcase
   end

   // next result
   always_comb begin
      kind_in  = KIND_WRITE;
      wstat_in = WSTAT_INSERTED;
      otype_in = '0;
      oref_in  = '0;
      stop_in  = STOP_NONE;
      last_in  = 1'b1;
      case (cmd.rsp_sel)
         RSP_INSERTED: wstat_in = WSTAT_INSERTED;
         RSP_REPLACED: wstat_in = WSTAT_REPLACED;
         RSP_DROPPED:  wstat_in = WSTAT_DROPPED;
         RSP_EMPTY:    kind_in  = KIND_EMPTY;
         RSP_EXEC: begin
            kind_in  = KIND_ENTRY;
            otype_in = rd_type_ff;
            oref_in  = 32'(rd_handle_ff);
            stop_in  = rd_stop;
            last_in  = stat.ex_fin;
         end
         default: begin
         end
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_all) begin
         type_mem[wr_addr] <= wr_type;
         rank_mem[wr_addr] <= wr_rank;
      end
      if (wr_all || wr_handle) begin
         handle_mem[wr_addr] <= wr_handle_data;
      end
      if (rd_en) begin
         rd_type_ff   <= type_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
         rd_rank_ff   <= rank_mem[rd_addr];
      end
   end

   // request capture and result register
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         cmd_type_ff   <= req_action_type;
         cmd_handle_ff <= req_action_ref[KEEP-1:0];
         cmd_rank_ff   <= rank_of(req_action_type);
      end
      if (cmd.rsp_load) begin
         kind_ff  <= kind_in;
         wstat_ff <= wstat_in;
         otype_ff <= otype_in;
         oref_ff  <= oref_in;
         stop_ff  <= stop_in;
         last_ff  <= last_in;
      end
      match_idx_ff <= match_idx_in;
      rd_idx_ff    <= rd_idx_in;
      pos_ff       <= pos_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         match_ff     <= 1'b0;
         pos_found_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_vld_in;
         match_ff     <= match_in;
         pos_found_ff <= pos_found_in;
      end
   end

   assign rsp_kind         = kind_ff;
   assign rsp_write_status = wstat_ff;
   assign rsp_out_type     = otype_ff;
   assign rsp_out_ref      = oref_ff;
   assign rsp_stop_cause   = stop_ff;
   assign rsp_last         = last_ff;

endmodule

// File: rtl/oast_ctrl.sv
// ----------------------------------------------------------------------------
// oast_ctrl
// Controller: sequences write, clear and execute and owns the handshakes.
// ----------------------------------------------------------------------------
module oast_ctrl
   import oast_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLACE,
      ST_SHIFT_PREP,
      ST_SHIFT,
      ST_INSERT,
      ST_RESP,
      ST_EX_READ,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   rsp_sel_type sel_ff, sel_in;
   logic        ready_ff, ready_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        slot_free;

   assign accept    = req_valid && ready_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cmd.op       = DP_NOP;
      cmd.rsp_load = 1'b0;
      cmd.rsp_sel  = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_WRITE: begin
                     cmd.op   = DP_LOAD;
                     state_in = ST_SCAN;
                  end
                  MODE_CLEAR: begin
                     cmd.op = DP_CLEAR;
                  end
                  MODE_EXECUTE: begin
                     cmd.op = DP_LOAD;
                     if (stat.empty) begin
                        sel_in   = RSP_EMPTY;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_EX_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.op = DP_SCAN;
            if (stat.scan_done) begin
               if (stat.match) begin
                  state_in = ST_REPLACE;
               end else if (stat.full) begin
                  sel_in   = RSP_DROPPED;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SHIFT_PREP;
               end
            end
         end
         ST_REPLACE: begin
            cmd.op   = DP_REPLACE;
            sel_in   = RSP_REPLACED;
            state_in = ST_RESP;
         end
         ST_SHIFT_PREP: begin
            cmd.op   = DP_SHIFT_PREP;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.op = DP_SHIFT;
            if (stat.shift_done) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.op   = DP_INSERT;
            sel_in   = RSP_INSERTED;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EX_READ: begin
            cmd.op   = DP_EX_READ;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.rsp_sel = RSP_EXEC;
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               if (stat.ex_fin) begin
                  cmd.op   = DP_EX_END;
                  state_in = ST_IDLE;
               end else begin
                  cmd.op = DP_EX_NEXT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid and input ready
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      ready_in = state_in == ST_IDLE;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= RSP_INSERTED;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/ordered_action_set_table.sv
// ----------------------------------------------------------------------------
// ordered_action_set_table
// Action set of one packet, kept sorted by action precedence rank.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item: mode (write, clear, execute), action type
//   and action handle. rsp_ channel returns results: one write status per
//   write, one item per executed entry, or one empty marker for an execute
//   on an empty set. rsp_last marks the final result of an item; a clear
//   returns nothing.
//   A write scans every stored entry once (one memory read per cycle), then
//   moves the entries behind the insert point up by one (one per cycle).
//   Execute emits one entry per cycle unless a stalled rsp_ready holds it.
//   The single read port of the entry memory sets these rates.
//   One item is worked on at a time; req_ready returns once its results are
//   all in the output register, which may still hold one result.
//   Reset empties the set and drops any result not yet taken; req_ready
//   rises in the cycle after reset is released. A stalled rsp_ready holds the
//   pending result and pauses the execute sequence.
// ----------------------------------------------------------------------------
`include "ordered_action_set_table_macros.svh"

module ordered_action_set_table
   import oast_pkg::*;
#(
   parameter int SET_DEPTH   = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_action_type,
   input  logic [31:0] req_action_ref,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_write_status,
   output logic [15:0] rsp_out_type,
   output logic [31:0] rsp_out_ref,
   output logic [1:0]  rsp_stop_cause,
   output logic        rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing
   oast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // entry storage and result register
   oast_dp #(
      .SET_DEPTH   (SET_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action_type  (req_action_type),
      .req_action_ref   (req_action_ref),
      .rsp_kind         (rsp_kind),
      .rsp_write_status (rsp_write_status),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_ref      (rsp_out_ref),
      .rsp_stop_cause   (rsp_stop_cause),
      .rsp_last         (rsp_last)
   );

   // a pending result is never overwritten before it is taken
   `OAST_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || rsp_ready)
   // status and empty markers are single results
   `OAST_ASSERT_SAME(a_single_last, clock, reset, rsp_valid && rsp_kind != KIND_ENTRY, rsp_last)
   // a clear leaves the set empty
   `OAST_ASSERT_NEXT(a_clear_empties, clock, reset, req_valid && req_ready && req_mode == MODE_CLEAR, stat.empty)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered action set table. Writes, clears and
// executes are driven as packet-like sequences and a scoreboard keeps its
// own sorted copy of the set to predict every write status and executed
// entry, across phases of sender gaps, receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import oast_pkg::*;

   localparam int          TABLE_DEPTH    = 16;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          DRAIN_CYCLES   = 60;
   localparam logic [1:0]  MODE_UNUSED    = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [15:0] req_action_type;
   logic [31:0] req_action_ref;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_write_status;
   logic [15:0] rsp_out_type;
   logic [31:0] rsp_out_ref;
   logic [1:0]  rsp_stop_cause;
   logic        rsp_last;

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_off_req;
   int items_sent;
   int quiet_cycles;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  wstat;
      logic [15:0] typ;
      logic [31:0] handle;
      logic [1:0]  stop;
      logic        last;
   } action_rsp_type;

   // sorted copy of the action set and the results it predicts
   class action_set_scoreboard;
      logic [15:0]     slot_typ[TABLE_DEPTH];
      logic [31:0]     slot_hd[TABLE_DEPTH];
      logic [3:0]      slot_rk[TABLE_DEPTH];
      int              fill_count;
      action_rsp_type  expected_rsp[$];
      int              mismatches;

      function new();
         fill_count = 0;
         mismatches = 0;
      endfunction

      function logic [3:0] precedence_of(logic [15:0] ty);
         case (ty)
            TYPE_COPY_TTL_IN:                              return RANK_10;
            TYPE_POP_VLAN, TYPE_POP_MPLS, TYPE_POP_PBB:    return RANK_20;
            TYPE_PUSH_VLAN, TYPE_PUSH_MPLS, TYPE_PUSH_PBB: return RANK_30;
            TYPE_COPY_TTL_OUT:                             return RANK_40;
            TYPE_DEC_MPLS_TTL, TYPE_DEC_NW_TTL:            return RANK_50;
            TYPE_SET_MPLS_TTL, TYPE_SET_NW_TTL,
            TYPE_SET_FIELD:                                return RANK_60;
            TYPE_SET_QUEUE:                                return RANK_70;
            TYPE_EXPERIMENTER:                             return RANK_75;
            TYPE_GROUP:                                    return RANK_80;
            TYPE_OUTPUT:                                   return RANK_90;
            default:                                       return RANK_79;
         endcase
      endfunction

      function void push_rsp(logic [1:0] kind, logic [1:0] wstat, logic [15:0] typ,
                             logic [31:0] handle, logic [1:0] stop, logic last);
         action_rsp_type r;
         r.kind   = kind;
         r.wstat  = wstat;
         r.typ    = typ;
         r.handle = handle;
         r.stop   = stop;
         r.last   = last;
         expected_rsp.push_back(r);
      endfunction

      // accepted item: update the set and queue the results it causes
      function void note_request(logic [1:0] mode, logic [15:0] ty, logic [31:0] handle);
         logic [3:0] rk;
         logic [1:0] stop;
         int         pos;
         case (mode)
            MODE_WRITE: begin
               rk = precedence_of(ty);
               if (ty != TYPE_SET_FIELD) begin
                  for (int i = 0; i < fill_count; i++) begin
                     if (slot_typ[i] == ty) begin
                        slot_hd[i] = handle;
                        push_rsp(KIND_WRITE, WSTAT_REPLACED, '0, '0, STOP_NONE, 1'b1);
                        return;
                     end
                  end
               end
               if (fill_count >= TABLE_DEPTH) begin
                  push_rsp(KIND_WRITE, WSTAT_DROPPED, '0, '0, STOP_NONE, 1'b1);
                  return;
               end
               // insert before the first entry of higher rank
               pos = fill_count;
               for (int i = fill_count - 1; i >= 0; i--)
                  if (rk < slot_rk[i]) pos = i;
               for (int i = fill_count; i > pos; i--) begin
                  slot_typ[i] = slot_typ[i-1];
                  slot_hd[i]  = slot_hd[i-1];
                  slot_rk[i]  = slot_rk[i-1];
               end
               slot_typ[pos] = ty;
               slot_hd[pos]  = handle;
               slot_rk[pos]  = rk;
               fill_count++;
               push_rsp(KIND_WRITE, WSTAT_INSERTED, '0, '0, STOP_NONE, 1'b1);
            end
            MODE_CLEAR: fill_count = 0;
            MODE_EXECUTE: begin
               if (fill_count == 0) begin
                  push_rsp(KIND_EMPTY, WSTAT_INSERTED, '0, '0, STOP_NONE, 1'b1);
               end else begin
                  // emit in order up to the first group or output entry
                  for (int i = 0; i < fill_count; i++) begin
                     if (slot_typ[i] == TYPE_GROUP)       stop = STOP_GROUP;
                     else if (slot_typ[i] == TYPE_OUTPUT) stop = STOP_OUTPUT;
                     else                                 stop = STOP_NONE;
                     push_rsp(KIND_ENTRY, WSTAT_INSERTED, slot_typ[i], slot_hd[i], stop,
                              (stop != STOP_NONE) || (i + 1 == fill_count));
                     if (stop != STOP_NONE) break;
                  end
               end
               fill_count = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [1:0] wstat, logic [15:0] typ,
                                 logic [31:0] handle, logic [1:0] stop, logic last);
         action_rsp_type e;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: kind %0d wstat %0d type %h ref %h stop %0d last %0d",
                        kind, wstat, typ, handle, stop, last);
            return;
         end
         e = expected_rsp.pop_front();
         if (e.kind !== kind || e.wstat !== wstat || e.typ !== typ ||
             e.handle !== handle || e.stop !== stop || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind %0d wstat %0d type %h ref %h stop %0d last %0d / %s",
                        e.kind, e.wstat, e.typ, e.handle, e.stop, e.last,
                        $sformatf("got kind %0d wstat %0d type %h ref %h stop %0d last %0d",
                                  kind, wstat, typ, handle, stop, last));
         end
      endfunction
   endclass

   action_set_scoreboard set_model = new();

   ordered_action_set_table DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_action_type  (req_action_type),
      .req_action_ref   (req_action_ref),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_write_status (rsp_write_status),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_ref      (rsp_out_ref),
      .rsp_stop_cause   (rsp_stop_cause),
      .rsp_last         (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result checking and watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            set_model.check_result(rsp_kind, rsp_write_status, rsp_out_type, rsp_out_ref,
                                   rsp_stop_cause, rsp_last);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [15:0] known_type(int idx);
      case (idx)
         0:       return TYPE_OUTPUT;
         1:       return TYPE_COPY_TTL_OUT;
         2:       return TYPE_COPY_TTL_IN;
         3:       return TYPE_SET_MPLS_TTL;
         4:       return TYPE_DEC_MPLS_TTL;
         5:       return TYPE_PUSH_VLAN;
         6:       return TYPE_POP_VLAN;
         7:       return TYPE_PUSH_MPLS;
         8:       return TYPE_POP_MPLS;
         9:       return TYPE_SET_QUEUE;
         10:      return TYPE_GROUP;
         11:      return TYPE_SET_NW_TTL;
         12:      return TYPE_DEC_NW_TTL;
         13:      return TYPE_SET_FIELD;
         14:      return TYPE_PUSH_PBB;
         15:      return TYPE_POP_PBB;
         default: return TYPE_EXPERIMENTER;
      endcase
   endfunction

   // fill packets lean on set-field and unknown types to overflow the table
   function automatic logic [15:0] pick_type(bit fill);
      int r;
      r = $urandom_range(99);
      if (fill) return (r < 50) ? TYPE_SET_FIELD : 16'($urandom_range(65535));
      if (r < 20) return TYPE_SET_FIELD;
      if (r < 80) return known_type($urandom_range(16));
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic [31:0] pick_handle();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // offer one item, with a random gap first, and wait for its acceptance
   task automatic send_item(logic [1:0] mode, logic [15:0] ty, logic [31:0] handle);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_mode        = mode;
      req_action_type = ty;
      req_action_ref  = handle;
      do @(posedge clock); while (!(req_valid && req_ready));
      set_model.note_request(mode, ty, handle);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // one packet: optional execute, clear and unused-mode items, a run of writes, then execute or clear
   task automatic send_packet();
      bit fill;
      int n_writes;
      fill = ($urandom_range(99) < 15);
      if ($urandom_range(99) < 5)
         send_item(MODE_EXECUTE, 16'($urandom), pick_handle());
      if ($urandom_range(99) < 12)
         send_item(MODE_CLEAR, 16'($urandom), pick_handle());
      if ($urandom_range(99) < 5)
         send_item(MODE_UNUSED, 16'($urandom), pick_handle());
      n_writes = fill ? $urandom_range(16, 20) : $urandom_range(1, 8);
      repeat (n_writes) send_item(MODE_WRITE, pick_type(fill), pick_handle());
      if ($urandom_range(99) < 90)
         send_item(MODE_EXECUTE, 16'($urandom), pick_handle());
      else
         send_item(MODE_CLEAR, 16'($urandom), pick_handle());
   endtask

   task automatic run_phase(int s_pct, int r_pct, int item_goal);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      while (items_sent < item_goal) send_packet();
   endtask

   // stimulus
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_WRITE;
      req_action_type = '0;
      req_action_ref  = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_req    = 1'b0;
      items_sent      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // execute on an empty set, then an ignored mode
      send_item(MODE_EXECUTE, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      // mixed ranks, repeated set-field, same-type replace, run ended by group
      send_item(MODE_WRITE, TYPE_OUTPUT, 32'hFFFF_FFFF);
      send_item(MODE_WRITE, TYPE_GROUP, 32'h0000_0000);
      send_item(MODE_WRITE, TYPE_EXPERIMENTER, 32'h1234_5678);
      send_item(MODE_WRITE, TYPE_COPY_TTL_IN, 32'hA5A5_A5A5);
      send_item(MODE_WRITE, TYPE_SET_FIELD, 32'h0000_0001);
      send_item(MODE_WRITE, TYPE_SET_FIELD, 32'h0000_0002);
      send_item(MODE_WRITE, 16'h8000, 32'h8000_0000);
      send_item(MODE_WRITE, TYPE_GROUP, 32'h5A5A_5A5A);
      send_item(MODE_EXECUTE, 16'h0000, 32'h0000_0000);
      // run ended by output
      send_item(MODE_WRITE, TYPE_OUTPUT, 32'h0000_0000);
      send_item(MODE_WRITE, TYPE_POP_VLAN, 32'h0F0F_0F0F);
      send_item(MODE_EXECUTE, 16'h0000, 32'h0000_0000);
      // no group or output entry: everything is emitted
      send_item(MODE_WRITE, TYPE_PUSH_MPLS, 32'h7FFF_FFFF);
      send_item(MODE_WRITE, TYPE_DEC_NW_TTL, 32'h0000_FFFF);
      send_item(MODE_WRITE, TYPE_SET_QUEUE, 32'hFFFF_0000);
      send_item(MODE_EXECUTE, 16'h0000, 32'h0000_0000);
      // clear then execute gives the empty marker
      send_item(MODE_WRITE, TYPE_COPY_TTL_OUT, 32'hDEAD_BEEF);
      send_item(MODE_CLEAR, 16'h0000, 32'h0000_0000);
      send_item(MODE_EXECUTE, 16'h0000, 32'h0000_0000);

      // random packets over the idling phases
      run_phase(0, 0, items_sent + 34);
      run_phase(65, 0, items_sent + 34);
      run_phase(0, 65, items_sent + 34);
      run_phase(6, 6, items_sent + 34);
      hold_off_req = 1'b1;
      run_phase(0, 0, items_sent + 34);

      @(negedge clock);
      req_valid = 1'b0;
      recv_stall_pct = 0;

      // drain
      while (set_model.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (set_model.mismatches == 0 && set_model.expected_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
